[rtl/fcc_pkg.sv]
`timescale 1ns / 1ps
// Package for the full-convolution FIR core: widths, register codes, stage tag
// and sequencer state. No dependencies.
package fcc_pkg;

  localparam int TAPS_DEF        = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COEF_W      = 16;
  localparam int RES_W       = 36;
  localparam int COEF_LANES  = 4;
  localparam int COEF_WORDS  = 4;
  localparam int COEF_MAX    = COEF_LANES * COEF_WORDS;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int TAP_COUNT_W = 5;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd1;

  typedef struct packed {
    logic valid;
    logic eos;
  } tag_t;

  typedef enum logic {
    ST_STREAM,
    ST_FLUSH
  } fcc_state_e;

endpackage

[rtl/fcc_tap_cell.sv]
`timescale 1ns / 1ps
// One tap of the delay chain: a sample register fed by its neighbor and a
// registered coefficient product. Depends on fcc_pkg.
module fcc_tap_cell #(
  parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       shift_i,
  input  logic                                       zero_i,
  input  logic signed [SAMPLE_BITS-1:0]              sample_i,
  input  logic signed [fcc_pkg::COEF_W-1:0]          coef_i,
  input  logic                                       load_i,
  output logic signed [SAMPLE_BITS-1:0]              sample_o,
  output logic signed [fcc_pkg::COEF_W+SAMPLE_BITS-1:0] product_o
);

  logic signed [SAMPLE_BITS-1:0]                     delay_q, delay_d;
  logic signed [fcc_pkg::COEF_W+SAMPLE_BITS-1:0]     product_q, product_d;

  always_comb begin
    delay_d = delay_q;
    if (shift_i) begin
      delay_d = zero_i ? '0 : sample_i;
    end
  end

  assign product_d = coef_i * delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else begin
      delay_q <= delay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      product_q <= product_d;
    end
  end

  assign sample_o  = delay_q;
  assign product_o = product_q;

endmodule

[rtl/fcc_adder_tree.sv]
`timescale 1ns / 1ps
// Registered binary adder tree over the tap products, one level per stage,
// with per-stage valid tags and stall handling. Depends on fcc_pkg.
module fcc_adder_tree #(
  parameter int TAPS   = fcc_pkg::TAPS_DEF,
  parameter int PROD_W = fcc_pkg::COEF_W + fcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fcc_pkg::tag_t                    tag_i,
  input  logic signed [PROD_W-1:0]         prod_i [TAPS],
  output logic                             ready_o,
  output fcc_pkg::tag_t                    tag_o,
  output logic [fcc_pkg::RES_W-1:0]        sum_o,
  input  logic                             ready_i
);

  localparam int RES_W  = fcc_pkg::RES_W;
  localparam int LEVELS = ($clog2(TAPS) < 1) ? 1 : $clog2(TAPS);
  localparam int LEAVES = 1 << LEVELS;
  localparam int EXT_W  = (PROD_W > RES_W) ? PROD_W : RES_W;

  logic [RES_W-1:0]   leaf   [LEAVES];
  logic [RES_W-1:0]   node_q [1:LEAVES-1];
  fcc_pkg::tag_t      tag_q  [1:LEVELS];
  logic               load   [1:LEVELS+1];

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < TAPS) begin : g_used
      logic signed [EXT_W-1:0] ext;
      assign ext     = EXT_W'(prod_i[j]);
      assign leaf[j] = ext[RES_W-1:0];
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  always_comb begin
    load[LEVELS+1] = ready_i;
    for (int s = LEVELS; s >= 1; s--) begin
      load[s] = !tag_q[s].valid || load[s+1];
    end
  end

  for (genvar i = 1; i < LEAVES; i++) begin : g_node
    localparam int DEPTH = $clog2(i + 1) - 1;
    localparam int STAGE = LEVELS - DEPTH;
    if (2 * i >= LEAVES) begin : g_bottom
      always_ff @(posedge clk_i) begin
        if (load[STAGE]) begin
          node_q[i] <= leaf[2*i-LEAVES] + leaf[2*i+1-LEAVES];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        if (load[STAGE]) begin
          node_q[i] <= node_q[2*i] + node_q[2*i+1];
        end
      end
    end
  end

  for (genvar s = 1; s <= LEVELS; s++) begin : g_tag
    fcc_pkg::tag_t tag_in;
    if (s == 1) begin : g_first
      assign tag_in = tag_i;
    end else begin : g_next
      assign tag_in = tag_q[s-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (load[s]) begin
        tag_q[s] <= tag_in;
      end
    end
  end

  assign ready_o = load[1];
  assign tag_o   = tag_q[LEVELS];
  assign sum_o   = node_q[1];

endmodule

[rtl/fir_full_convolution_core.sv]
`timescale 1ns / 1ps
// Top level of the full-convolution FIR core: configuration registers, tail
// sequencer, chain of tap cells and adder tree. Depends on fcc_pkg,
// fcc_tap_cell and fcc_adder_tree.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request per sample with
//   sample_i and final_sample_i. Each sample yields one result on the output
//   channel (out_valid_o/out_ready_i). A final sample also yields n-1 tail
//   results (n: tap_count clamped to 1..TAPS); the last result of a signal has
//   end_of_signal_o high, and the next signal starts from a cleared line.
//   Configuration requests (cfg_valid_i, cfg_index_i, cfg_data_i) are always
//   taken; write them only while the core is idle.
//   Throughput: one sample per cycle while the output does not stall; a final
//   sample holds in_ready_o low while n-1 zero samples shift into the chain.
//   A result is presented after its sample passes the delay shift, the product
//   register, the adder tree levels and the output register.
//   Reset clears the delay line and coefficients and sets tap_count to 16.
//   When the receiver stalls, each stage holds and empty stages still fill;
//   in_ready_o drops once the whole pipeline is full.
module fir_full_convolution_core #(
  parameter int TAPS        = fcc_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fcc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic                                 final_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fcc_pkg::RES_W-1:0]     result_o,
  output logic                                 end_of_signal_o
);

  localparam int COEF_W = fcc_pkg::COEF_W;
  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int COEF_N = (TAPS < fcc_pkg::COEF_MAX) ? TAPS : fcc_pkg::COEF_MAX;
  localparam int NW     = $clog2(TAPS + 1);

  logic [fcc_pkg::TAP_COUNT_W-1:0]  tap_count_q;
  logic signed [COEF_W-1:0]         coef_q [COEF_N];
  logic [NW-1:0]                    n_taps;

  fcc_pkg::fcc_state_e              state_q, state_d;
  logic [NW-1:0]                    tail_q, tail_d;
  logic                             clear_q;
  fcc_pkg::tag_t                    s0_q, s1_q, out_q, tree_tag;

  logic                             accept, flush_step, shift, eos_shift;
  logic                             en0, load1, tree_ready, load_out;
  logic signed [SAMPLE_BITS-1:0]    head_sample;
  logic signed [SAMPLE_BITS-1:0]    chain   [TAPS];
  logic signed [COEF_W-1:0]         coef_eff[TAPS];
  logic signed [PROD_W-1:0]         product [TAPS];
  logic [fcc_pkg::RES_W-1:0]        tree_sum;
  logic signed [fcc_pkg::RES_W-1:0] result_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fcc_pkg::TAP_COUNT_RST;
      for (int t = 0; t < COEF_N; t++) begin
        coef_q[t] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fcc_pkg::REG_TAP_COUNT) begin
        tap_count_q <= cfg_data_i[fcc_pkg::TAP_COUNT_W-1:0];
      end
      for (int t = 0; t < COEF_N; t++) begin
        if (cfg_index_i == fcc_pkg::REG_COEF_0 + fcc_pkg::CFG_IDX_W'(t / fcc_pkg::COEF_LANES)) begin
          coef_q[t] <= cfg_data_i[(t % fcc_pkg::COEF_LANES)*COEF_W +: COEF_W];
        end
      end
    end
  end

  always_comb begin
    if (tap_count_q == '0) begin
      n_taps = NW'(1);
    end else if (int'(tap_count_q) > TAPS) begin
      n_taps = NW'(TAPS);
    end else begin
      n_taps = NW'(tap_count_q);
    end
  end

  // tail sequencer
  assign en0       = !s0_q.valid || load1;
  assign accept    = in_valid_i && in_ready_o;
  assign shift     = accept || flush_step;
  assign eos_shift = (accept && final_sample_i && n_taps == NW'(1))
                  || (flush_step && tail_q == NW'(1));

  always_comb begin
    state_d = state_q;
    tail_d  = tail_q;
    unique case (state_q)
      fcc_pkg::ST_STREAM: begin
        if (accept && final_sample_i && n_taps != NW'(1)) begin
          state_d = fcc_pkg::ST_FLUSH;
          tail_d  = n_taps - NW'(1);
        end
      end
      fcc_pkg::ST_FLUSH: begin
        if (flush_step) begin
          tail_d = tail_q - NW'(1);
          if (tail_q == NW'(1)) begin
            state_d = fcc_pkg::ST_STREAM;
          end
        end
      end
      default: state_d = fcc_pkg::ST_STREAM;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    flush_step = 1'b0;
    unique case (state_q)
      fcc_pkg::ST_STREAM: in_ready_o = en0;
      fcc_pkg::ST_FLUSH:  flush_step = en0;
      default: begin
        in_ready_o = 1'b0;
        flush_step = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcc_pkg::ST_STREAM;
      tail_q  <= '0;
      clear_q <= 1'b0;
      s0_q    <= '0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
      if (shift) begin
        clear_q <= eos_shift;
        s0_q    <= '{valid: 1'b1, eos: eos_shift};
      end else if (load1) begin
        s0_q.valid <= 1'b0;
      end
    end
  end

  // tap chain
  assign head_sample = flush_step ? '0 : sample_i;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    logic signed [SAMPLE_BITS-1:0] cell_in;
    logic                          cell_zero;
    if (k == 0) begin : g_head
      assign cell_in   = head_sample;
      assign cell_zero = 1'b0;
    end else begin : g_body
      assign cell_in   = chain[k-1];
      assign cell_zero = clear_q;
    end
    if (k < COEF_N) begin : g_coef
      assign coef_eff[k] = (k < int'(n_taps)) ? coef_q[k] : '0;
    end else begin : g_nocoef
      assign coef_eff[k] = '0;
    end
    fcc_tap_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .zero_i   (cell_zero),
      .sample_i (cell_in),
      .coef_i   (coef_eff[k]),
      .load_i   (load1),
      .sample_o (chain[k]),
      .product_o(product[k])
    );
  end

  assign load1 = !s1_q.valid || tree_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (load1) begin
      s1_q <= s0_q;
    end
  end

  fcc_adder_tree #(
    .TAPS  (TAPS),
    .PROD_W(PROD_W)
  ) u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s1_q),
    .prod_i (product),
    .ready_o(tree_ready),
    .tag_o  (tree_tag),
    .sum_o  (tree_sum),
    .ready_i(load_out)
  );

  // output register
  assign load_out = !out_q.valid || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (load_out) begin
      out_q <= tree_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      result_q <= tree_sum;
    end
  end

  assign out_valid_o     = out_q.valid;
  assign end_of_signal_o = out_q.eos;
  assign result_o        = result_q;

  a_flush_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fcc_pkg::ST_FLUSH |-> tail_q != '0)
    else $error("flush state with empty tail count");

  a_flush_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_sample_i && n_taps != NW'(1))
    |=> (state_q == fcc_pkg::ST_FLUSH) && (tail_q == $past(n_taps) - NW'(1)))
    else $error("final sample did not start the tail");

  a_eos_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eos_shift |=> (state_q == fcc_pkg::ST_STREAM) && clear_q && s0_q.eos)
    else $error("end of signal did not close the tail");

  a_no_input_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_step |-> !accept)
    else $error("sample taken during tail flush");

endmodule

[tb/tb_fir_full_convolution_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fir_full_convolution_core: a directed table and then random
// signals, with random idling on both channels outside the steady phases, checked against a
// behavioral convolution model or the table's known results. Depends on fcc_pkg and the core RTL.
module tb_fir_full_convolution_core;

  localparam int TAPS    = fcc_pkg::TAPS_DEF;
  localparam int SMP_W   = fcc_pkg::SAMPLE_BITS_DEF;
  localparam int LAT     = $clog2(TAPS) + 2;
  localparam int IDLE_PC = 17;

  typedef enum logic {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct {
    row_kind_e                          kind;
    logic [fcc_pkg::CFG_IDX_W-1:0]      idx;
    logic [fcc_pkg::CFG_DATA_W-1:0]     data;
    logic signed [SMP_W-1:0]            smp;
    logic                               fin;
    logic                               known;
    logic signed [fcc_pkg::RES_W-1:0]   res;
    logic                               eos;
  } row_t;

  typedef struct {
    logic signed [fcc_pkg::RES_W-1:0] res;
    logic                             eos;
  } conv_out_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [fcc_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [fcc_pkg::CFG_DATA_W-1:0]      cfg_data_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic signed [SMP_W-1:0]             sample_i;
  logic                                final_sample_i;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [fcc_pkg::RES_W-1:0]    result_o;
  logic                                end_of_signal_o;

  logic signed [SMP_W-1:0]             dline [TAPS];
  logic signed [fcc_pkg::COEF_W-1:0]   coefs [TAPS];
  logic [fcc_pkg::TAP_COUNT_W-1:0]     taps_reg;
  conv_out_t                           pending_outputs [$];
  row_t                                script [$];
  bit                                  steady = 1'b0;
  int                                  mismatch_count = 0;

  fir_full_convolution_core #(
    .TAPS       (TAPS),
    .SAMPLE_BITS(SMP_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .final_sample_i (final_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result_o),
    .end_of_signal_o(end_of_signal_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2_400_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned active_taps();
    int unsigned n;
    n = taps_reg;
    if (n < 1) n = 1;
    if (n > TAPS) n = TAPS;
    return n;
  endfunction

  function automatic void shift_line(logic signed [SMP_W-1:0] s);
    for (int i = TAPS - 1; i > 0; i--) dline[i] = dline[i-1];
    dline[0] = s;
  endfunction

  function automatic logic signed [fcc_pkg::RES_W-1:0] line_dot(int unsigned n);
    longint acc;
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(coefs[k]) * longint'(dline[k]);
    return acc[fcc_pkg::RES_W-1:0];
  endfunction

  function automatic void apply_reg(logic [fcc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fcc_pkg::CFG_DATA_W-1:0] data);
    int w;
    w = int'(idx) - int'(fcc_pkg::REG_COEF_0);
    if (idx == fcc_pkg::REG_TAP_COUNT) begin
      taps_reg = data[fcc_pkg::TAP_COUNT_W-1:0];
    end else if (w >= 0 && w < fcc_pkg::COEF_WORDS) begin
      for (int k = 0; k < fcc_pkg::COEF_LANES; k++) begin
        coefs[w*fcc_pkg::COEF_LANES + k] = data[fcc_pkg::COEF_W*k +: fcc_pkg::COEF_W];
      end
    end
  endfunction

  // Convolution step: the sample's own result, then the zero-fed tail on a final sample.
  function automatic void conv_predict(logic signed [SMP_W-1:0] s, logic fin, logic known,
                                       logic signed [fcc_pkg::RES_W-1:0] kres, logic keos);
    int unsigned n;
    conv_out_t   o;
    n = active_taps();
    shift_line(s);
    o.res = line_dot(n);
    o.eos = fin && (n == 1);
    if (known) begin
      o.res = kres;
      o.eos = keos;
    end
    pending_outputs.push_back(o);
    if (fin) begin
      for (int unsigned t = 1; t < n; t++) begin
        shift_line('0);
        o.res = line_dot(n);
        o.eos = (t == n - 1);
        pending_outputs.push_back(o);
      end
      for (int i = 0; i < TAPS; i++) dline[i] = '0;
    end
  endfunction

  function automatic void add_write(logic [fcc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fcc_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_WRITE, idx: idx, data: data, smp: '0, fin: 1'b0, known: 1'b0,
          res: '0, eos: 1'b0};
    script.push_back(r);
  endfunction

  function automatic void add_sample(logic signed [SMP_W-1:0] s, logic fin, logic known,
                                     logic signed [fcc_pkg::RES_W-1:0] res, logic eos);
    row_t r;
    r = '{kind: ROW_SAMPLE, idx: '0, data: '0, smp: s, fin: fin, known: known,
          res: res, eos: eos};
    script.push_back(r);
  endfunction

  task automatic send_sample(logic signed [SMP_W-1:0] s, logic fin, logic known,
                             logic signed [fcc_pkg::RES_W-1:0] kres, logic keos);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PC) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    sample_i       <= s;
    final_sample_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    conv_predict(s, fin, known, kres, keos);
  endtask

  task automatic drain_outputs();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0 && guard < 50_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [fcc_pkg::CFG_IDX_W-1:0] idx,
                           logic [fcc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_outputs.size() == 0) begin
          $error("result: none expected, got %0d", result_o);
          mismatch_count++;
        end else begin
          if (result_o !== pending_outputs[0].res) begin
            $error("result: expected %0d, got %0d", pending_outputs[0].res, result_o);
            mismatch_count++;
          end
          if (end_of_signal_o !== pending_outputs[0].eos) begin
            $error("end_of_signal: expected %0b, got %0b", pending_outputs[0].eos,
                   end_of_signal_o);
            mismatch_count++;
          end
          void'(pending_outputs.pop_front());
        end
      end
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PC);
    end
  end

  initial begin
    logic [fcc_pkg::CFG_DATA_W-1:0] word;
    logic signed [SMP_W-1:0]        smp;
    int                             len;
    int                             pos;
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    sample_i       <= '0;
    final_sample_i <= 1'b0;
    for (int i = 0; i < TAPS; i++) begin
      dline[i] = '0;
      coefs[i] = '0;
    end
    taps_reg = fcc_pkg::TAP_COUNT_RST;

    // Zero coefficients after reset, then one tap at full negative scale.
    add_sample(16'sh7FFF, 1'b0, 1'b1, '0, 1'b0);
    add_sample(16'sh8000, 1'b1, 1'b1, '0, 1'b0);
    add_write(fcc_pkg::REG_TAP_COUNT, 64'd1);
    add_write(fcc_pkg::REG_COEF_0, 64'h0000_0000_0000_8000);
    add_sample(16'sh8000, 1'b1, 1'b1, 36'sd1073741824, 1'b1);
    add_sample(16'sh7FFF, 1'b0, 1'b1, -36'sd1073709056, 1'b0);
    add_sample(16'sh0000, 1'b1, 1'b1, '0, 1'b1);
    add_write(fcc_pkg::REG_TAP_COUNT, 64'd0);
    add_sample(16'sd12345, 1'b1, 1'b1, -36'sd404520960, 1'b1);
    add_write(fcc_pkg::REG_TAP_COUNT, 64'd31);
    add_sample(16'sh8000, 1'b1, 1'b1, 36'sd1073741824, 1'b0);
    // Full line of extremes: largest sum magnitude.
    add_write(fcc_pkg::REG_TAP_COUNT, 64'd16);
    for (int w = 0; w < fcc_pkg::COEF_WORDS; w++) begin
      add_write(fcc_pkg::CFG_IDX_W'(int'(fcc_pkg::REG_COEF_0) + w), 64'h8000_8000_8000_8000);
    end
    for (int i = 0; i < TAPS - 1; i++) add_sample(16'sh8000, 1'b0, 1'b0, '0, 1'b0);
    add_sample(16'sh8000, 1'b1, 1'b1, 36'sd17179869184, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        drain_outputs();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_sample(script[i].smp, script[i].fin, script[i].known, script[i].res,
                    script[i].eos);
      end
    end

    // Phases end mid-signal where they happen to, so the kept line meets a new setting.
    for (int ph = 0; ph < 8; ph++) begin
      drain_outputs();
      steady <= (ph == 3 || ph == 4);
      case (ph)
        0:       write_reg(fcc_pkg::REG_TAP_COUNT, 64'd16);
        1:       write_reg(fcc_pkg::REG_TAP_COUNT, 64'd1);
        2:       write_reg(fcc_pkg::REG_TAP_COUNT, 64'd0);
        3:       write_reg(fcc_pkg::REG_TAP_COUNT, 64'd31);
        4:       write_reg(fcc_pkg::REG_TAP_COUNT, 64'd17);
        default: write_reg(fcc_pkg::REG_TAP_COUNT,
                           fcc_pkg::CFG_DATA_W'($urandom_range(2, 15)));
      endcase
      for (int w = 0; w < fcc_pkg::COEF_WORDS; w++) begin
        case (ph)
          0:       word = 64'h7FFF_7FFF_7FFF_7FFF;
          1:       word = 64'h8000_8000_8000_8000;
          default: word = {$urandom, $urandom};
        endcase
        write_reg(fcc_pkg::CFG_IDX_W'(int'(fcc_pkg::REG_COEF_0) + w), word);
      end
      write_reg(fcc_pkg::CFG_IDX_W'($urandom_range(5, 7)), {$urandom, $urandom});
      len = $urandom_range(1, 6);
      pos = 0;
      for (int n = 0; n < 13; n++) begin
        case ($urandom_range(9))
          0:       smp = 16'sh8000;
          1:       smp = 16'sh7FFF;
          2:       smp = '0;
          default: smp = SMP_W'($urandom);
        endcase
        send_sample(smp, pos == len - 1, 1'b0, '0, 1'b0);
        pos++;
        if (pos == len) begin
          pos = 0;
          len = $urandom_range(1, 6);
        end
      end
    end

    steady <= 1'b0;
    drain_outputs();
    repeat (4 * LAT) @(posedge clk_i);
    if (pending_outputs.size() != 0) begin
      $error("result: %0d expected results never arrived", pending_outputs.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fcc_pkg.sv
rtl/fcc_tap_cell.sv
rtl/fcc_adder_tree.sv
rtl/fir_full_convolution_core.sv
tb/tb_fir_full_convolution_core.sv
